// File: rtl/core/u8srl_pkg.sv
// shared types and constants of the utf-8 symbol range locator
`default_nettype none

package u8srl_pkg;

	localparam int BYTE_W   = 8;
	localparam int SYM_W    = 16;
	localparam int SEEN_W   = 17;
	localparam int OFFSET_W = 16;
	localparam int LENGTH_W = 17;

	localparam logic [BYTE_W-1:0] ASCII_MAX = 8'h7f;
	localparam logic [BYTE_W-1:0] CONT_MASK = 8'hc0;
	localparam logic [BYTE_W-1:0] CONT_TAG  = 8'h80;

	typedef enum logic [1:0] {
		STATUS_OK      = 2'd0,
		STATUS_INVALID = 2'd1,
		STATUS_RANGE   = 2'd2
	} status_t;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              has_byte;
		logic              first_item;
		logic              last_item;
		logic [SYM_W-1:0]  start_symbol;
		logic [SYM_W-1:0]  symbol_count;
	} u8srl_item_t;

	typedef struct packed {
		status_t             status;
		logic [OFFSET_W-1:0] start_offset;
		logic [LENGTH_W-1:0] byte_length;
	} u8srl_result_t;

endpackage

`default_nettype wire

// File: rtl/core/u8srl_scan.sv
// per-string scan state: byte classification, symbol counting and range search
`default_nettype none

module u8srl_scan import u8srl_pkg::*; #(
	parameter int MAX_STRING_BYTES = 65536
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          take,
	input  wire u8srl_item_t   item,
	output u8srl_result_t      res
);

	localparam int POS_W = $clog2(MAX_STRING_BYTES + 1);
	localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(MAX_STRING_BYTES);

	typedef enum logic [1:0] {
		PH_SEEK_START = 2'd0,
		PH_SEEK_END   = 2'd1,
		PH_FOUND      = 2'd2,
		PH_ERROR      = 2'd3
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [POS_W-1:0]   pos_q, pos_d;
	logic [SEEN_W-1:0]  seen_q, seen_d;
	logic [1:0]         cont_q, cont_d;
	logic [POS_W-1:0]   fstart_q, fstart_d;
	logic [POS_W-1:0]   fend_q, fend_d;
	logic [SYM_W-1:0]   wstart_q, wstart_d;
	logic [SYM_W-1:0]   wcount_q, wcount_d;

	always_comb begin
		logic              done;
		logic [BYTE_W-1:0] b;
		logic [POS_W-1:0]  pos_after;
		logic [POS_W-1:0]  diff;

		phase_d  = phase_q;
		pos_d    = pos_q;
		seen_d   = seen_q;
		cont_d   = cont_q;
		fstart_d = fstart_q;
		fend_d   = fend_q;
		wstart_d = wstart_q;
		wcount_d = wcount_q;
		done     = 1'b0;
		b        = item.data_byte;
		pos_after = pos_q + POS_W'(1);

		if (item.first_item) begin
			phase_d  = PH_SEEK_START;
			pos_d    = '0;
			seen_d   = '0;
			cont_d   = '0;
			fstart_d = '0;
			fend_d   = '0;
			wstart_d = item.start_symbol;
			wcount_d = item.symbol_count;
		end

		pos_after = pos_d + POS_W'(1);

		if (item.has_byte && pos_d < POS_LIMIT) begin
			if (phase_d == PH_SEEK_START || phase_d == PH_SEEK_END) begin
				if (cont_d != 2'd0) begin
					if ((b & CONT_MASK) != CONT_TAG) begin
						phase_d = PH_ERROR;
					end else begin
						cont_d = cont_d - 2'd1;
						done   = (cont_d == 2'd0);
					end
				end else begin
					if (phase_d == PH_SEEK_START && seen_d == {1'b0, wstart_d})
						fstart_d = pos_d;
					if (b <= ASCII_MAX) begin
						done = 1'b1;
					end else if (b[7:5] == 3'b110) begin
						cont_d = 2'd1;
					end else if (b[7:4] == 4'b1110) begin
						cont_d = 2'd2;
					end else if (b[7:3] == 5'b11110) begin
						cont_d = 2'd3;
					end else begin
						phase_d = PH_ERROR;
					end
				end
			end
			pos_d = pos_after;
		end

		if (done) begin
			seen_d = seen_d + SEEN_W'(1);
			if (phase_d == PH_SEEK_START && seen_d == ({1'b0, wstart_d} + SEEN_W'(1))) begin
				if (wcount_d == '0) begin
					fend_d  = fstart_d;
					phase_d = PH_FOUND;
				end else if (wcount_d == SYM_W'(1)) begin
					fend_d  = pos_d;
					phase_d = PH_FOUND;
				end else begin
					phase_d = PH_SEEK_END;
				end
			end else if (phase_d == PH_SEEK_END &&
				     seen_d == ({1'b0, wstart_d} + {1'b0, wcount_d})) begin
				fend_d  = pos_d;
				phase_d = PH_FOUND;
			end
		end

		diff = fend_d - fstart_d;
		res.start_offset = '0;
		res.byte_length  = '0;
		if (phase_d == PH_ERROR) begin
			res.status = STATUS_INVALID;
		end else if (phase_d == PH_FOUND) begin
			res.status       = STATUS_OK;
			res.start_offset = OFFSET_W'(fstart_d);
			res.byte_length  = LENGTH_W'(diff);
		end else if (cont_d != 2'd0) begin
			res.status = STATUS_INVALID;
		end else begin
			res.status = STATUS_RANGE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_SEEK_START;
			pos_q    <= '0;
			seen_q   <= '0;
			cont_q   <= '0;
			fstart_q <= '0;
			fend_q   <= '0;
			wstart_q <= '0;
			wcount_q <= '0;
		end else if (take) begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			seen_q   <= seen_d;
			cont_q   <= cont_d;
			fstart_q <= fstart_d;
			fend_q   <= fend_d;
			wstart_q <= wstart_d;
			wcount_q <= wcount_d;
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/utf8_symbol_range_locator.sv
// utf-8 symbol range locator: input register, scan logic and result register
// result: registered in the result register when the last item of a string leaves the input register
// throughput: one item per cycle, set by the single scan stage; the input
// register holds only while a finished result waits at the output
// reset: clears all scan state, the latched query and both valid flags
`default_nettype none

module utf8_symbol_range_locator import u8srl_pkg::*; #(
	parameter int MAX_STRING_BYTES = 65536
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output      logic                in_stall,
	input  wire logic [BYTE_W-1:0]   data_byte,
	input  wire logic                has_byte,
	input  wire logic                first_item,
	input  wire logic                last_item,
	input  wire logic [SYM_W-1:0]    start_symbol,
	input  wire logic [SYM_W-1:0]    symbol_count,
	output      logic                out_valid,
	input  wire logic                out_stall,
	output      logic [1:0]          status,
	output      logic [OFFSET_W-1:0] start_offset,
	output      logic [LENGTH_W-1:0] byte_length
);

	logic          valid_s1;
	u8srl_item_t   item_s1;
	logic          advance;
	logic          in_xfer;
	u8srl_result_t scan_res;
	logic          out_valid_q;
	u8srl_result_t res_q;

	assign advance  = valid_s1 && (!item_s1.last_item || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			item_s1.data_byte    <= data_byte;
			item_s1.has_byte     <= has_byte;
			item_s1.first_item   <= first_item;
			item_s1.last_item    <= last_item;
			item_s1.start_symbol <= start_symbol;
			item_s1.symbol_count <= symbol_count;
		end
	end

	u8srl_scan #(
		.MAX_STRING_BYTES(MAX_STRING_BYTES)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (advance),
		.item   (item_s1),
		.res    (scan_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && item_s1.last_item) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && item_s1.last_item) begin
			res_q <= scan_res;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign start_offset = res_q.start_offset;
	assign byte_length  = res_q.byte_length;

endmodule

`default_nettype wire

// File: tb/sv/utf8_symbol_range_locator_test.sv
// self-checking testbench of the utf-8 symbol range locator: directed and random strings, scan predictor
`timescale 1ns / 100ps

module utf8_symbol_range_locator_test;
	import u8srl_pkg::*;

	localparam int MAX_BYTES   = 65536;
	localparam int CYCLE_LIMIT = 700000;
	localparam int RAND_ITEMS  = 1200;

	typedef enum logic [1:0] {
		SEEK_START = 2'd0,
		SEEK_END   = 2'd1,
		FOUND      = 2'd2,
		HALTED     = 2'd3
	} scan_phase_t;

	typedef struct {
		u8srl_item_t item;
		int unsigned gap;
	} pending_t;

	logic                clk          = 1'b0;
	logic                arst_n       = 1'b0;
	logic                in_valid     = 1'b0;
	logic                in_stall;
	logic [BYTE_W-1:0]   data_byte    = '0;
	logic                has_byte     = 1'b0;
	logic                first_item   = 1'b0;
	logic                last_item    = 1'b0;
	logic [SYM_W-1:0]    start_symbol = '0;
	logic [SYM_W-1:0]    symbol_count = '0;
	logic                out_valid;
	logic                out_stall    = 1'b0;
	logic [1:0]          status;
	logic [OFFSET_W-1:0] start_offset;
	logic [LENGTH_W-1:0] byte_length;

	utf8_symbol_range_locator #(
		.MAX_STRING_BYTES(MAX_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.has_byte(has_byte),
		.first_item(first_item),
		.last_item(last_item),
		.start_symbol(start_symbol),
		.symbol_count(symbol_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.start_offset(start_offset),
		.byte_length(byte_length)
	);

	always #6 clk = ~clk;

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// scan state of the predictor
	logic [16:0]       scan_pos;
	logic [16:0]       scan_seen;
	logic [1:0]        scan_cont;
	scan_phase_t       scan_phase;
	logic [15:0]       scan_start_off;
	logic [16:0]       scan_end_off;
	logic              scan_err;
	logic [SYM_W-1:0]  query_start;
	logic [SYM_W-1:0]  query_count;

	pending_t      pending_items[$];
	u8srl_result_t expected_results[$];
	logic [7:0]    str_bytes[$];
	bit            tx_burst;
	bit            rx_burst;
	int            item_count;
	int            errors;
	int            cycles;

	function void clear_scan();
		scan_pos       = '0;
		scan_seen      = '0;
		scan_cont      = '0;
		scan_phase     = SEEK_START;
		scan_start_off = '0;
		scan_end_off   = '0;
		scan_err       = 1'b0;
	endfunction

	function void close_symbol(input logic [16:0] pos_after);
		scan_seen = scan_seen + 17'd1;
		if (scan_phase == SEEK_START && 18'(scan_seen) == 18'(query_start) + 18'd1) begin
			if (query_count == 16'd0) begin
				scan_end_off = 17'(scan_start_off);
				scan_phase   = FOUND;
			end else if (query_count == 16'd1) begin
				scan_end_off = pos_after;
				scan_phase   = FOUND;
			end else begin
				scan_phase = SEEK_END;
			end
		end else if (scan_phase == SEEK_END &&
				18'(scan_seen) == 18'(query_start) + 18'(query_count)) begin
			scan_end_off = pos_after;
			scan_phase   = FOUND;
		end
	endfunction

	function void scan_byte(input logic [7:0] b);
		logic [16:0] p;
		p = scan_pos;
		if (int'(p) >= MAX_BYTES)
			return;
		scan_pos = p + 17'd1;
		if (scan_phase != SEEK_START && scan_phase != SEEK_END)
			return;
		if (scan_cont != 2'd0) begin
			if ((b & CONT_MASK) != CONT_TAG) begin
				scan_err   = 1'b1;
				scan_phase = HALTED;
				return;
			end
			scan_cont = scan_cont - 2'd1;
			if (scan_cont == 2'd0)
				close_symbol(p + 17'd1);
			return;
		end
		if (scan_phase == SEEK_START && scan_seen == 17'(query_start))
			scan_start_off = p[15:0];
		casez (b)
			8'b0???????: close_symbol(p + 17'd1);
			8'b110?????: scan_cont = 2'd1;
			8'b1110????: scan_cont = 2'd2;
			8'b11110???: scan_cont = 2'd3;
			default: begin
				scan_err   = 1'b1;
				scan_phase = HALTED;
			end
		endcase
	endfunction

	function bit scan_item(input u8srl_item_t it, output u8srl_result_t res);
		res = '0;
		if (it.first_item) begin
			clear_scan();
			query_start = it.start_symbol;
			query_count = it.symbol_count;
		end
		if (it.has_byte)
			scan_byte(it.data_byte);
		if (!it.last_item)
			return 1'b0;
		if (scan_phase == HALTED || scan_err) begin
			res.status = STATUS_INVALID;
		end else if (scan_phase == FOUND) begin
			res.status       = STATUS_OK;
			res.start_offset = scan_start_off;
			res.byte_length  = scan_end_off - 17'(scan_start_off);
		end else if (scan_cont != 2'd0) begin
			res.status = STATUS_INVALID;
		end else begin
			res.status = STATUS_RANGE;
		end
		return 1'b1;
	endfunction

	function u8srl_item_t mk(input logic [7:0] b, input logic has, input logic first,
			input logic last, input logic [15:0] st, input logic [15:0] cnt);
		u8srl_item_t it;
		it.data_byte    = b;
		it.has_byte     = has;
		it.first_item   = first;
		it.last_item    = last;
		it.start_symbol = st;
		it.symbol_count = cnt;
		return it;
	endfunction

	function void add_item(input u8srl_item_t it);
		pending_t p;
		p.item = it;
		p.gap  = tx_burst ? 0 : $urandom_range(0, 11);
		pending_items.push_back(p);
		if (it.has_byte || it.last_item)
			item_count++;
	endfunction

	function void send_string(input logic [15:0] st, input logic [15:0] cnt, input int hole_pct);
		u8srl_item_t parts[$];
		parts.delete();
		foreach (str_bytes[i]) begin
			if ($urandom_range(0, 99) < hole_pct)
				parts.push_back(mk(8'($urandom), 1'b0, 1'b0, 1'b0, 16'($urandom),
					16'($urandom)));
			parts.push_back(mk(str_bytes[i], 1'b1, 1'b0, 1'b0, 16'($urandom), 16'($urandom)));
		end
		if (parts.size() == 0)
			parts.push_back(mk(8'($urandom), 1'b0, 1'b0, 1'b0, 16'($urandom), 16'($urandom)));
		parts[0].first_item              = 1'b1;
		parts[0].start_symbol            = st;
		parts[0].symbol_count            = cnt;
		parts[parts.size() - 1].last_item = 1'b1;
		foreach (parts[i])
			add_item(parts[i]);
	endfunction

	function void add_symbol();
		int len;
		len = $urandom_range(1, 4);
		case (len)
			1: str_bytes.push_back({1'b0, 7'($urandom)});
			2: str_bytes.push_back({3'b110, 5'($urandom)});
			3: str_bytes.push_back({4'b1110, 4'($urandom)});
			default: str_bytes.push_back({5'b11110, 3'($urandom)});
		endcase
		repeat (len - 1) str_bytes.push_back({2'b10, 6'($urandom)});
	endfunction

	function void corrupt_string();
		int at;
		at = (str_bytes.size() > 0) ? $urandom_range(0, str_bytes.size() - 1) : 0;
		case ($urandom_range(0, 3))
			0: if (str_bytes.size() > 0) str_bytes[at] = 8'($urandom);
			1: repeat ($urandom_range(1, 3)) if (str_bytes.size() > 0) void'(str_bytes.pop_back());
			2: str_bytes.push_back(8'($urandom));
			default: str_bytes.insert(at, {2'b10, 6'($urandom)});
		endcase
	endfunction

	// input side: one transfer per accepted item
	pending_t      next_p;
	u8srl_item_t   cur_item;
	u8srl_result_t got_res;
	int unsigned   wait_cnt;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (scan_item(cur_item, got_res))
					expected_results.push_back(got_res);
			end
			if (!in_valid || !in_stall) begin
				if (pending_items.size() == 0) begin
					in_valid <= 1'b0;
				end else if (wait_cnt < pending_items[0].gap) begin
					wait_cnt++;
					in_valid <= 1'b0;
				end else begin
					next_p       = pending_items.pop_front();
					cur_item     = next_p.item;
					wait_cnt     = 0;
					in_valid     <= 1'b1;
					data_byte    <= cur_item.data_byte;
					has_byte     <= cur_item.has_byte;
					first_item   <= cur_item.first_item;
					last_item    <= cur_item.last_item;
					start_symbol <= cur_item.start_symbol;
					symbol_count <= cur_item.symbol_count;
				end
			end
		end
	end

	// output side
	u8srl_result_t want;
	int            stall_left;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					if (errors < 10)
						$display("unexpected result: status %0d offset %0d length %0d",
							status, start_offset, byte_length);
					errors++;
				end else begin
					want = expected_results.pop_front();
					if (status !== want.status || start_offset !== want.start_offset ||
							byte_length !== want.byte_length) begin
						if (errors < 10)
							$display("mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
								want.status, want.start_offset, want.byte_length,
								status, start_offset, byte_length);
						errors++;
					end
				end
				if ($urandom_range(0, 15) == 0)
					rx_burst = !rx_burst;
				stall_left = rx_burst ? 0 : $urandom_range(0, 11);
				out_stall <= (stall_left != 0);
			end else if (out_stall) begin
				if (stall_left > 1) begin
					stall_left--;
				end else begin
					stall_left = 0;
					out_stall  <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("utf8_symbol_range_locator_test: FAIL");
			$finish;
		end
	end

	initial begin
		int          n_sym;
		int          st;
		int          cnt;
		int          extra;
		u8srl_item_t tail_it;

		clear_scan();
		query_start = '0;
		query_count = '0;

		// directed strings
		tx_burst = 1'b0;
		str_bytes.delete();
		send_string(16'd0, 16'd0, 0);
		str_bytes = '{8'h7f};
		send_string(16'd0, 16'd1, 0);
		str_bytes = '{8'hc0, 8'h80, 8'he0, 8'hbf, 8'hbf, 8'h00};
		send_string(16'd1, 16'd2, 0);
		str_bytes = '{8'hf7, 8'hbf, 8'hbf};
		send_string(16'd0, 16'd1, 0);
		str_bytes = '{8'h41, 8'hf8};
		send_string(16'd1, 16'd0, 0);
		str_bytes = '{8'h41, 8'h42, 8'hff};
		send_string(16'd0, 16'd1, 0);
		str_bytes = '{8'hdf, 8'h41};
		send_string(16'd0, 16'd0, 0);
		str_bytes = '{8'h41};
		send_string(16'd1, 16'd0, 0);
		str_bytes = '{8'h41};
		send_string(16'hffff, 16'hffff, 0);
		add_item(mk(8'h80, 1'b1, 1'b0, 1'b1, 16'h5a5a, 16'ha5a5));
		add_item(mk(8'h41, 1'b1, 1'b1, 1'b0, 16'd1, 16'd0));
		add_item(mk(8'hff, 1'b0, 1'b0, 1'b0, 16'hffff, 16'hffff));
		add_item(mk(8'h42, 1'b1, 1'b0, 1'b1, 16'd0, 16'd0));
		str_bytes.delete();

		// random strings, mostly well formed
		item_count = 0;
		while (item_count < RAND_ITEMS) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			n_sym = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
			str_bytes.delete();
			repeat (n_sym) add_symbol();
			st  = $urandom_range(0, n_sym);
			cnt = $urandom_range(0, n_sym - st + 1);
			if ($urandom_range(0, 9) == 0)
				st = $urandom_range(0, 65535);
			if ($urandom_range(0, 9) == 0)
				cnt = $urandom_range(0, 65535);
			if ($urandom_range(0, 9) < 3)
				corrupt_string();
			send_string(16'(st), 16'(cnt), 5);
			if ($urandom_range(0, 19) == 0) begin
				extra = $urandom_range(1, 3);
				for (int k = 0; k < extra; k++) begin
					tail_it = mk(8'($urandom), 1'($urandom), 1'b0, k == extra - 1,
						16'($urandom), 16'($urandom));
					add_item(tail_it);
				end
			end
		end

		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (errors == 0)
			$display("utf8_symbol_range_locator_test: PASS");
		else
			$display("utf8_symbol_range_locator_test: FAIL");
		$finish;
	end

endmodule

// File: files.f
rtl/core/u8srl_pkg.sv
rtl/core/u8srl_scan.sv
rtl/core/utf8_symbol_range_locator.sv
tb/sv/utf8_symbol_range_locator_test.sv
